// ===== rtl/tlsd_pkg.sv =====
// Package for the TLS record stream deframer: phase codes, header field
// limits, status codes and the state and result structs shared by the RTL.
// No dependencies.
`default_nettype none

package tlsd_pkg;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_BODY    = 2'd1,
		PH_NOT_TLS = 2'd2,
		PH_BROKEN  = 2'd3
	} phase_t;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOT_TLS = 2'd1;
	localparam logic [1:0] STATUS_BROKEN  = 2'd2;

	localparam logic [7:0]  TYPE_MIN       = 8'h14;
	localparam logic [7:0]  TYPE_MAX       = 8'h17;
	localparam logic [7:0]  VER_MAJOR      = 8'h03;
	localparam logic [7:0]  VER_MINOR_MAX  = 8'h04;
	localparam logic [15:0] MAX_LEN_RESET  = 16'd18432;

	// Header byte positions.
	localparam logic [2:0] POS_TYPE      = 3'd0;
	localparam logic [2:0] POS_MAJOR     = 3'd1;
	localparam logic [2:0] POS_MINOR     = 3'd2;
	localparam logic [2:0] POS_LEN_HIGH  = 3'd3;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  header_position;
		logic [7:0]  current_type;
		logic [15:0] current_length;
		logic [15:0] body_remaining;
	} state_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        in_header;
		logic [7:0]  record_type;
		logic [15:0] body_length;
		logic        record_end;
		logic [1:0]  status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/tls_record_stream_deframer.sv =====
// TLS record stream deframer, top level: input register, parser state,
// result register and the body length limit register.
// Depends on tlsd_pkg and tlsd_step.
//
// Usage: bytes of an in-order client stream enter one per beat on the data
// channel (data_valid, data_byte; the block drives data_stall). Each byte
// leaves as one result beat on the result channel (result_valid and the
// result fields; the receiver drives result_stall): the byte itself, a
// header tag, the record type and body length, a record end mark and the
// stream status. A byte accepted into the input register moves into the
// result register once that register can take a beat, and is then held
// there until the receiver takes it. While the receiver does not stall,
// the block sustains one byte per cycle; the only loop is the parser
// state, updated as a byte moves from the input to the result register.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and data_stall rises once both hold a byte; nothing is
// dropped. Reset returns the parser to the first header byte with status
// ok, empties both registers and restores the body length limit to 18432.
// The limit is written over the cfg channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high, and writes are meant to happen only
// while no byte is in flight.
`default_nettype none

module tls_record_stream_deframer import tlsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,

	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        in_header,
	output logic [7:0]  record_type,
	output logic [15:0] body_length,
	output logic        record_end,
	output logic [1:0]  status
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res_nxt;
	logic [15:0] max_len_q;
	logic        advance;

	// The result register can take a new beat when empty or being drained.
	assign advance    = !valid_s2 || !result_stall;
	assign data_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	tlsd_step u_step (
		.cur             (state_q),
		.data_byte       (byte_s1),
		.max_body_length (max_len_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	// Input register and body length limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (!data_stall)
				valid_s1 <= data_valid;
			if (cfg_valid && cfg_ready)
				max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall)
			byte_s1 <= data_byte;
	end

	// Parser state and result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2                <= 1'b0;
			state_q.phase           <= PH_HEADER;
			state_q.header_position <= POS_TYPE;
			state_q.current_type    <= 8'h00;
			state_q.current_length  <= 16'h0000;
			state_q.body_remaining  <= 16'h0000;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res_nxt;
	end

	assign result_valid = valid_s2;
	assign out_byte     = res_s2.out_byte;
	assign in_header    = res_s2.in_header;
	assign record_type  = res_s2.record_type;
	assign body_length  = res_s2.body_length;
	assign record_end   = res_s2.record_end;
	assign status       = res_s2.status;

endmodule

`default_nettype wire

// ===== rtl/tlsd_step.sv =====
// Per-byte deframing logic: next parser state and the tagged result beat.
// Purely combinational; depends on tlsd_pkg.
`default_nettype none

module tlsd_step import tlsd_pkg::*; (
	input  state_t      cur,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_body_length,
	output state_t      nxt,
	output result_t     res
);

	logic [15:0] full_length;
	logic [15:0] remaining_dec;

	assign full_length   = {cur.current_length[15:8], data_byte};
	assign remaining_dec = cur.body_remaining - 16'd1;

	always_comb begin
		nxt                 = cur;
		res.out_byte        = data_byte;
		res.in_header       = 1'b0;
		res.record_type     = 8'h00;
		res.body_length     = 16'h0000;
		res.record_end      = 1'b0;

		unique case (cur.phase)
			PH_HEADER: begin
				res.in_header = 1'b1;
				unique case (cur.header_position)
					POS_TYPE: begin
						nxt.current_type    = data_byte;
						nxt.current_length  = 16'h0000;
						if (data_byte < TYPE_MIN || data_byte > TYPE_MAX)
							nxt.phase = PH_NOT_TLS;
						nxt.header_position = POS_MAJOR;
					end
					POS_MAJOR: begin
						if (data_byte != VER_MAJOR)
							nxt.phase = PH_NOT_TLS;
						nxt.header_position = POS_MINOR;
					end
					POS_MINOR: begin
						if (data_byte > VER_MINOR_MAX)
							nxt.phase = PH_NOT_TLS;
						nxt.header_position = POS_LEN_HIGH;
					end
					POS_LEN_HIGH: begin
						// The high byte alone can already exceed the limit.
						nxt.current_length = {data_byte, 8'h00};
						if ({data_byte, 8'h00} > max_body_length)
							nxt.phase = PH_BROKEN;
						nxt.header_position = cur.header_position + 3'd1;
					end
					default: begin
						nxt.current_length  = full_length;
						nxt.header_position = POS_TYPE;
						res.body_length     = full_length;
						if (full_length > max_body_length) begin
							nxt.phase = PH_BROKEN;
						end else if (full_length == 16'h0000) begin
							// Empty body: the header closes the record.
							res.record_end = 1'b1;
						end else begin
							nxt.body_remaining = full_length;
							nxt.phase          = PH_BODY;
						end
					end
				endcase
				res.record_type = nxt.current_type;
			end
			PH_BODY: begin
				res.record_type    = cur.current_type;
				res.body_length    = cur.current_length;
				nxt.body_remaining = remaining_dec;
				if (remaining_dec == 16'h0000) begin
					res.record_end      = 1'b1;
					nxt.phase           = PH_HEADER;
					nxt.header_position = POS_TYPE;
				end
			end
			default: begin
				// Sticky error phases: echo only.
			end
		endcase

		unique case (nxt.phase)
			PH_NOT_TLS: res.status = STATUS_NOT_TLS;
			PH_BROKEN:  res.status = STATUS_BROKEN;
			default:    res.status = STATUS_OK;
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/tls_record_stream_deframer_tb.sv =====
// Self-checking testbench for tls_record_stream_deframer: a clocked driver,
// a clocked monitor and a cycle-free model of the record parser.
// Depends on tlsd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tls_record_stream_deframer_tb import tlsd_pkg::*;;

	localparam int          IDLE_PCT        = 12;
	localparam int          QUIET_FROM      = 1000;
	localparam int          QUIET_TO        = 1300;
	localparam int          LONG_HOLD_AT    = 700;
	localparam int          LONG_HOLD_BEATS = 120;
	localparam int          SETTLE_CYCLES   = 6;
	localparam logic [2:0]  POS_LEN_LOW     = 3'd4;

	// The ways the closing record of the run can break the stream.
	typedef enum int {
		FAULT_TYPE,
		FAULT_MAJOR,
		FAULT_MINOR,
		FAULT_LEN_HIGH,
		FAULT_LEN_LOW
	} stream_fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        in_header;
	logic [7:0]  record_type;
	logic [15:0] body_length;
	logic        record_end;
	logic [1:0]  status;

	// Bytes still to be offered, and the tagged beats the deframer owes us.
	logic [7:0] stream_bytes[$];
	result_t    tagged_bytes_due[$];

	// Shadow of the parser: its state and the body length limit it checks.
	phase_t      parse_phase = PH_HEADER;
	logic [2:0]  header_pos = POS_TYPE;
	logic [7:0]  record_kind = '0;
	logic [15:0] record_len = '0;
	logic [15:0] body_left = '0;
	logic [15:0] length_limit = MAX_LEN_RESET;

	int    bytes_sent = 0;
	int    results_checked = 0;
	int    records_framed = 0;
	int    limits_written = 0;
	int    failures = 0;
	int    hold_left = 0;
	bit    long_hold_done = 1'b0;
	string fault_name = "none";

	tls_record_stream_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.in_header    (in_header),
		.record_type  (record_type),
		.body_length  (body_length),
		.record_end   (record_end),
		.status       (status)
	);

	always #4 clk = ~clk;

	// Advances the shadow parser by one stream byte and returns the beat the
	// deframer has to produce for it. A header byte that decides a bad
	// status is still tagged as header; once the stream is marked not TLS or
	// broken, bytes only pass through with all tags cleared.
	function automatic result_t frame_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte = b;
		case (parse_phase)
			PH_HEADER: begin
				r.in_header = 1'b1;
				case (header_pos)
					POS_TYPE: begin
						record_kind = b;
						record_len = '0;
						if (b < TYPE_MIN || b > TYPE_MAX)
							parse_phase = PH_NOT_TLS;
						header_pos = POS_MAJOR;
					end
					POS_MAJOR: begin
						if (b != VER_MAJOR)
							parse_phase = PH_NOT_TLS;
						header_pos = POS_MINOR;
					end
					POS_MINOR: begin
						if (b > VER_MINOR_MAX)
							parse_phase = PH_NOT_TLS;
						header_pos = POS_LEN_HIGH;
					end
					POS_LEN_HIGH: begin
						// The high byte alone can already exceed the limit.
						record_len = {b, 8'h00};
						if (record_len > length_limit)
							parse_phase = PH_BROKEN;
						header_pos = POS_LEN_LOW;
					end
					default: begin
						record_len[7:0] = b;
						r.body_length = record_len;
						header_pos = POS_TYPE;
						if (record_len > length_limit) begin
							parse_phase = PH_BROKEN;
						end else if (record_len == '0) begin
							// An empty body closes the record on its last header byte.
							r.record_end = 1'b1;
						end else begin
							body_left = record_len;
							parse_phase = PH_BODY;
						end
					end
				endcase
				r.record_type = record_kind;
			end
			PH_BODY: begin
				r.record_type = record_kind;
				r.body_length = record_len;
				body_left = body_left - 16'd1;
				if (body_left == '0) begin
					r.record_end = 1'b1;
					parse_phase = PH_HEADER;
					header_pos = POS_TYPE;
				end
			end
			default: ;
		endcase
		case (parse_phase)
			PH_NOT_TLS: r.status = STATUS_NOT_TLS;
			PH_BROKEN:  r.status = STATUS_BROKEN;
			default:    r.status = STATUS_OK;
		endcase
		if (r.record_end)
			records_framed++;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	// Driver. A beat accepted at this edge is predicted at once; a new byte
	// is offered only once the current one has gone, so a stalled byte holds.
	// The sender idles now and then, except inside the quiet window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			data_byte <= '0;
		end else begin
			if (data_valid && !data_stall) begin
				tagged_bytes_due.push_back(frame_byte(data_byte));
				bytes_sent++;
			end
			if (!data_valid || !data_stall) begin
				if (stream_bytes.size() != 0 &&
						((bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					data_valid <= 1'b1;
					data_byte <= stream_bytes.pop_front();
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Checks each accepted result beat against the oldest prediction
	// and drives the receiver's stall: random, none in the quiet window, and
	// one long hold-off that lets the deframer fill and push back on the
	// sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (tagged_bytes_due.size() == 0) begin
					$error("result beat with nothing expected: out_byte 0x%0h", out_byte);
					failures++;
				end else begin
					result_t want;
					want = tagged_bytes_due.pop_front();
					check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
					check_field("in_header", 32'(want.in_header), 32'(in_header));
					check_field("record_type", 32'(want.record_type), 32'(record_type));
					check_field("body_length", 32'(want.body_length), 32'(body_length));
					check_field("record_end", 32'(want.record_end), 32'(record_end));
					check_field("status", 32'(want.status), 32'(status));
				end
				results_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_BEATS;
				result_stall <= 1'b1;
			end else if (results_checked >= QUIET_FROM && results_checked < QUIET_TO) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Waits until every queued byte has come back checked, then lets the
	// pipeline settle. Returns on a falling edge.
	task automatic wait_drained();
		@(negedge clk);
		while (stream_bytes.size() != 0 || data_valid || tagged_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the body length limit; only called while nothing is in flight.
	task automatic write_length_limit(input logic [15:0] limit);
		logic taken;
		taken = 1'b0;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= limit;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		length_limit = limit;
		limits_written++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] good_type();
		return 8'($urandom_range(TYPE_MAX, TYPE_MIN));
	endfunction

	task automatic queue_record(input logic [7:0] kind, input logic [7:0] minor,
			input logic [15:0] len);
		stream_bytes.push_back(kind);
		stream_bytes.push_back(VER_MAJOR);
		stream_bytes.push_back(minor);
		stream_bytes.push_back(len[15:8]);
		stream_bytes.push_back(len[7:0]);
		for (int i = 0; i < len; i++)
			stream_bytes.push_back(8'($urandom_range(255)));
	endtask

	// Well-formed records with random content; empty bodies and bodies right
	// at the cap are favored, and an empty body ends its record on the header.
	task automatic queue_random_records(input int cap, input int budget);
		int queued;
		int len;
		int pick;
		queued = 0;
		while (queued < budget) begin
			pick = $urandom_range(5);
			if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = cap;
			else
				len = $urandom_range(cap);
			queue_record(good_type(), 8'($urandom_range(VER_MINOR_MAX)), 16'(len));
			queued += 5 + len;
		end
	endtask

	// One header that breaks the stream, chosen at random, followed by noise
	// that must pass through untagged once the status has stuck.
	task automatic queue_stream_fault();
		logic [7:0]    hdr[5];
		stream_fault_t fault;
		hdr[0] = good_type();
		hdr[1] = VER_MAJOR;
		hdr[2] = 8'($urandom_range(VER_MINOR_MAX));
		hdr[3] = 8'h00;
		hdr[4] = 8'($urandom_range(length_limit));
		fault = stream_fault_t'($urandom_range(FAULT_LEN_LOW));
		case (fault)
			FAULT_TYPE: begin
				while (hdr[0] >= TYPE_MIN && hdr[0] <= TYPE_MAX)
					hdr[0] = 8'($urandom_range(255));
				fault_name = "not TLS after a bad content type";
			end
			FAULT_MAJOR: begin
				while (hdr[1] == VER_MAJOR)
					hdr[1] = 8'($urandom_range(255));
				fault_name = "not TLS after a bad major version";
			end
			FAULT_MINOR: begin
				hdr[2] = 8'($urandom_range(255, VER_MINOR_MAX + 1));
				fault_name = "not TLS after a bad minor version";
			end
			FAULT_LEN_HIGH: begin
				hdr[3] = 8'($urandom_range(255, 1));
				fault_name = "broken on the high length byte";
			end
			default: begin
				hdr[4] = 8'($urandom_range(255, length_limit + 1));
				fault_name = "broken on the low length byte";
			end
		endcase
		foreach (hdr[i])
			stream_bytes.push_back(hdr[i]);
		repeat (40)
			stream_bytes.push_back(8'($urandom_range(255)));
	endtask

	initial begin
		int cap;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed records under the reset limit: every content type, the
		// lowest and highest minor version, and an empty body first.
		queue_record(TYPE_MIN, 8'h00, 16'd0);
		queue_record(TYPE_MAX, VER_MINOR_MAX, 16'd1);
		queue_record(8'h15, 8'h03, 16'd2);
		queue_record(8'h16, 8'h01, 16'd3);
		wait_drained();

		// Widest limit, with one body long enough to carry a high length byte.
		write_length_limit(16'hFFFF);
		queue_record(8'h17, 8'h03, 16'h0123);
		queue_random_records(24, 150);
		wait_drained();

		// A zero limit admits only empty records.
		write_length_limit(16'h0000);
		repeat (12)
			queue_record(good_type(), 8'($urandom_range(VER_MINOR_MAX)), 16'd0);
		wait_drained();

		write_length_limit(16'd40);
		queue_random_records(40, 500);
		wait_drained();

		write_length_limit(16'($urandom_range(1000, 1)));
		cap = (length_limit < 48) ? int'(length_limit) : 48;
		queue_random_records(cap, 400);
		wait_drained();

		// Close the run with a fault, since the bad status sticks until reset.
		write_length_limit(16'd20);
		queue_random_records(20, 60);
		queue_stream_fault();
		wait_drained();

		$display("Covered %0d stream bytes, %0d complete records, %0d limit writes.",
			bytes_sent, records_framed, limits_written);
		$display("The stream ended %s.", fault_name);
		if (failures == 0)
			$display("** tls_record_stream_deframer: PASSED **");
		else
			$display("** tls_record_stream_deframer: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d beats still expected.", tagged_bytes_due.size());
		$display("** tls_record_stream_deframer: FAILED **");
		$finish;
	end

endmodule
